// File: rtl/hrsu_pkg.sv
// Shared types and constants for the half-resolution reference store upsampler.
package hrsu_pkg;

  localparam int FULL_ROWS_DEF    = 64;
  localparam int FULL_COLUMNS_DEF = 64;
  localparam int PIX_W            = 16;
  localparam int COORD_W          = 6;
  // Widest bank address over the whole parameter range (128 x 128 reduced, 4 banks).
  localparam int BANK_AW_MAX      = 12;
  localparam int Q_DEPTH          = 2;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  // One classified transaction as it waits between the front and the back.
  typedef struct packed {
    op_t                                kind;
    logic signed [PIX_W-1:0]            value;
    logic                               wr_en;
    logic [1:0]                         wr_bank;
    logic [BANK_AW_MAX-1:0]             wr_addr;
    logic [3:0][BANK_AW_MAX-1:0]        rd_addr;
    logic                               par_r;
    logic                               par_c;
    logic                               fy;
    logic                               fx;
    logic                               has_r;
    logic                               has_c;
  } q_entry_t;

endpackage

// File: rtl/hrsu_front.sv
// Front end: classifies each transaction and works out bank addresses and the block mean.
module hrsu_front #(
  parameter int FULL_ROWS    = 64,
  parameter int FULL_COLUMNS = 64
) (
  input  logic                                       in_kind,
  input  logic [hrsu_pkg::COORD_W-1:0]               in_row,
  input  logic [hrsu_pkg::COORD_W-1:0]               in_column,
  input  logic signed [hrsu_pkg::PIX_W-1:0]          in_top_left,
  input  logic signed [hrsu_pkg::PIX_W-1:0]          in_top_right,
  input  logic signed [hrsu_pkg::PIX_W-1:0]          in_bottom_left,
  input  logic signed [hrsu_pkg::PIX_W-1:0]          in_bottom_right,
  output hrsu_pkg::q_entry_t                         entry
);
  import hrsu_pkg::*;

  localparam int RED_ROWS  = FULL_ROWS / 2;
  localparam int RED_COLS  = FULL_COLUMNS / 2;
  localparam int BANK_COLS = (RED_COLS + 1) / 2;
  localparam int LAST_ROW  = 2 * RED_ROWS - 1;
  localparam int LAST_COL  = 2 * RED_COLS - 1;

  logic [COORD_W-1:0]       row_c;
  logic [COORD_W-1:0]       col_c;
  logic [COORD_W-2:0]       sr;
  logic [COORD_W-2:0]       sc;
  logic                     has_r;
  logic                     has_c;
  logic signed [PIX_W+1:0]  blk_sum;
  logic                     wr_in_range;
  logic [3:0][BANK_AW_MAX-1:0] rd_addr;

  // Coordinates beyond the last covered pixel saturate to it.
  assign row_c = (int'(in_row) > LAST_ROW) ? COORD_W'(LAST_ROW) : in_row;
  assign col_c = (int'(in_column) > LAST_COL) ? COORD_W'(LAST_COL) : in_column;
  assign sr    = row_c[COORD_W-1:1];
  assign sc    = col_c[COORD_W-1:1];
  assign has_r = (int'(sr) + 1) < RED_ROWS;
  assign has_c = (int'(sc) + 1) < RED_COLS;

  assign blk_sum = {{2{in_top_left[PIX_W-1]}}, in_top_left}
                 + {{2{in_top_right[PIX_W-1]}}, in_top_right}
                 + {{2{in_bottom_left[PIX_W-1]}}, in_bottom_left}
                 + {{2{in_bottom_right[PIX_W-1]}}, in_bottom_right};

  assign wr_in_range = (int'(in_row) < RED_ROWS) && (int'(in_column) < RED_COLS);

  // Each of the four neighbours falls into a different bank, chosen by row and column parity.
  always_comb begin : rd_addr_calc
    logic [1:0]         bb;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
    logic               ok;
    for (int b = 0; b < 4; b++) begin
      bb = 2'(b);
      y  = (bb[1] == sr[0]) ? {1'b0, sr} : {1'b0, sr} + COORD_W'(1);
      x  = (bb[0] == sc[0]) ? {1'b0, sc} : {1'b0, sc} + COORD_W'(1);
      ok = (bb[1] == sr[0] || has_r) && (bb[0] == sc[0] || has_c);
      rd_addr[b] = ok ? BANK_AW_MAX'(int'(y[COORD_W-1:1]) * BANK_COLS + int'(x[COORD_W-1:1]))
                      : '0;
    end
  end

  always_comb begin
    entry.kind    = op_t'(in_kind);
    entry.value   = blk_sum[PIX_W+1:2];
    entry.wr_en   = wr_in_range;
    entry.wr_bank = {in_row[0], in_column[0]};
    entry.wr_addr = BANK_AW_MAX'(int'(in_row[COORD_W-1:1]) * BANK_COLS
                                + int'(in_column[COORD_W-1:1]));
    entry.rd_addr = rd_addr;
    entry.par_r   = sr[0];
    entry.par_c   = sc[0];
    entry.fy      = row_c[0];
    entry.fx      = col_c[0];
    entry.has_r   = has_r;
    entry.has_c   = has_c;
  end

endmodule

// File: rtl/hrsu_queue.sv
// Two-entry queue that decouples the front end from the store back end.
module hrsu_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  hrsu_pkg::q_entry_t  push_data,
  output logic                pop_valid,
  input  logic                pop,
  output hrsu_pkg::q_entry_t  pop_data
);
  import hrsu_pkg::*;

  q_entry_t   slots_r [Q_DEPTH];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       push;

  assign push_ready = count_r != 2'(Q_DEPTH);
  assign pop_valid  = count_r != 2'd0;
  assign pop_data   = slots_r[rd_ptr_r];
  assign push       = push_valid && push_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(Q_DEPTH))
    else $error("queue occupancy above its depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != 2'd0)
    else $error("queue popped while empty");
  a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 2'd1)
    else $error("queue occupancy did not follow a lone push");
`endif

endmodule

// File: rtl/hrsu_back.sv
// Back end: four store banks, neighbour read and reconstruction, result register.
module hrsu_back #(
  parameter int FULL_ROWS    = 64,
  parameter int FULL_COLUMNS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  hrsu_pkg::q_entry_t                 q_data,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [hrsu_pkg::PIX_W-1:0]  out_pixel_value
);
  import hrsu_pkg::*;

  localparam int RED_ROWS   = FULL_ROWS / 2;
  localparam int RED_COLS   = FULL_COLUMNS / 2;
  localparam int BANK_ROWS  = (RED_ROWS + 1) / 2;
  localparam int BANK_COLS  = (RED_COLS + 1) / 2;
  localparam int BANK_DEPTH = BANK_ROWS * BANK_COLS;
  localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  logic                     issue;
  logic                     s2_stall;
  logic                     s2_move;
  logic                     s2_valid_r;
  logic                     s2_valid_nxt;
  q_entry_t                 s2_ent_r;
  logic signed [PIX_W-1:0]  bank_q [4];
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic signed [PIX_W-1:0]  out_value_r;
  logic signed [PIX_W-1:0]  recon;

  assign s2_stall = s2_valid_r && out_valid_r && !out_ready;
  assign s2_move  = s2_valid_r && !s2_stall;
  assign issue    = q_valid && !s2_stall;
  assign q_pop    = issue;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic signed [PIX_W-1:0] mem [BANK_DEPTH];
    logic signed [PIX_W-1:0] rd_data_r;

    always_ff @(posedge clk) begin
      if (issue && q_data.kind == OP_STORE && q_data.wr_en && q_data.wr_bank == 2'(b)) begin
        mem[q_data.wr_addr[AW-1:0]] <= q_data.value;
      end
      if (issue && q_data.kind == OP_READ) begin
        rd_data_r <= mem[q_data.rd_addr[b][AW-1:0]];
      end
    end

    assign bank_q[b] = rd_data_r;
  end

  // Rounded mean for the full bilinear case, truncated mean at the last reduced row or column.
  always_comb begin : recon_calc
    logic signed [PIX_W+1:0] v00;
    logic signed [PIX_W+1:0] v01;
    logic signed [PIX_W+1:0] v10;
    logic signed [PIX_W+1:0] v11;
    logic                    full;
    logic                    inc01;
    logic                    inc10;
    logic                    inc11;
    logic signed [PIX_W+1:0] sum;
    logic signed [PIX_W+1:0] bias;
    logic signed [PIX_W+1:0] biased;
    v00 = (PIX_W+2)'(bank_q[{s2_ent_r.par_r, s2_ent_r.par_c}]);
    v01 = (PIX_W+2)'(bank_q[{s2_ent_r.par_r, ~s2_ent_r.par_c}]);
    v10 = (PIX_W+2)'(bank_q[{~s2_ent_r.par_r, s2_ent_r.par_c}]);
    v11 = (PIX_W+2)'(bank_q[{~s2_ent_r.par_r, ~s2_ent_r.par_c}]);
    full  = s2_ent_r.has_r && s2_ent_r.has_c;
    inc01 = s2_ent_r.has_c && (s2_ent_r.has_r ? s2_ent_r.fx : 1'b1);
    inc10 = s2_ent_r.has_r && (s2_ent_r.has_c ? s2_ent_r.fy : 1'b1);
    inc11 = full && s2_ent_r.fx && s2_ent_r.fy;
    sum = v00 + (inc01 ? v01 : '0) + (inc10 ? v10 : '0) + (inc11 ? v11 : '0);
    if (full) begin
      bias = (PIX_W+2)'({inc01 && inc10, inc01 ^ inc10});
    end else begin
      bias = (PIX_W+2)'((inc01 || inc10) && sum[PIX_W+1]);
    end
    biased = sum + bias;
    unique case ({inc01, inc10})
      2'b00:        recon = biased[PIX_W-1:0];
      2'b01, 2'b10: recon = biased[PIX_W:1];
      2'b11:        recon = biased[PIX_W+1:2];
      default:      recon = biased[PIX_W-1:0];
    endcase
  end

  always_comb begin
    if (issue) begin
      s2_valid_nxt = 1'b1;
    end else if (!s2_stall) begin
      s2_valid_nxt = 1'b0;
    end else begin
      s2_valid_nxt = s2_valid_r;
    end
    if (s2_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s2_ent_r <= q_data;
    end
    if (s2_move) begin
      out_value_r <= (s2_ent_r.kind == OP_STORE) ? s2_ent_r.value : recon;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_value_r;

`ifndef SYNTH
  a_no_issue_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> !s2_stall)
    else $error("transaction issued while the reconstruction stage was stalled");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s2_stall |=> s2_valid_r)
    else $error("stalled reconstruction stage lost its transaction");
  a_issue_fills: assert property (@(posedge clk) disable iff (!rst_n)
    issue |=> s2_valid_r)
    else $error("issued transaction did not reach the reconstruction stage");
`endif

endmodule

// File: rtl/half_res_reference_store_upsampler.sv
// Top level of the half-resolution reference store with 2x downsample and upsample.
// The queue, the bank read and reconstruction stage and the output register are pipelined;
// throughput is one transaction per cycle while out_ready is high.
// A read in the cycle after a store sees that store, as banks are written at issue.
// Reset (rst_n, synchronous) empties the queue and pipeline; store contents are kept.
// Store entries are undefined until written; there is no clearing pass.
module half_res_reference_store_upsampler #(
  parameter int FULL_ROWS    = hrsu_pkg::FULL_ROWS_DEF,
  parameter int FULL_COLUMNS = hrsu_pkg::FULL_COLUMNS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_kind,
  input  logic [hrsu_pkg::COORD_W-1:0]       in_row,
  input  logic [hrsu_pkg::COORD_W-1:0]       in_column,
  input  logic signed [hrsu_pkg::PIX_W-1:0]  in_top_left,
  input  logic signed [hrsu_pkg::PIX_W-1:0]  in_top_right,
  input  logic signed [hrsu_pkg::PIX_W-1:0]  in_bottom_left,
  input  logic signed [hrsu_pkg::PIX_W-1:0]  in_bottom_right,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [hrsu_pkg::PIX_W-1:0]  out_pixel_value
);
  import hrsu_pkg::*;

  q_entry_t front_entry;
  q_entry_t q_data;
  logic     q_valid;
  logic     q_pop;

  hrsu_front #(
    .FULL_ROWS    (FULL_ROWS),
    .FULL_COLUMNS (FULL_COLUMNS)
  ) u_front (
    .in_kind         (in_kind),
    .in_row          (in_row),
    .in_column       (in_column),
    .in_top_left     (in_top_left),
    .in_top_right    (in_top_right),
    .in_bottom_left  (in_bottom_left),
    .in_bottom_right (in_bottom_right),
    .entry           (front_entry)
  );

  hrsu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_entry),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  hrsu_back #(
    .FULL_ROWS    (FULL_ROWS),
    .FULL_COLUMNS (FULL_COLUMNS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_value (out_pixel_value)
  );

endmodule
